// ===== src/fct_pkg.sv =====
// Shared types and codes for the frustum cull tester.
// No dependencies.
package fct_pkg;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_POINT  = 2'd1;
  localparam logic [1:0] MODE_SPHERE = 2'd2;
  localparam logic [1:0] MODE_BOX    = 2'd3;

  localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
  localparam logic [1:0] VERDICT_INSIDE  = 2'd1;
  localparam logic [1:0] VERDICT_OVERLAP = 2'd2;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned NormalW = 16;
  localparam int unsigned ProdW   = CoordW + NormalW;
  localparam int unsigned DistW   = ProdW + 3;
  localparam int unsigned FracSh  = 15;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [CoordW-1:0] pz;
    logic [CoordW-1:0] fx;
    logic [CoordW-1:0] fy;
    logic [CoordW-1:0] fz;
    logic [CoordW-1:0] rad;
  } fct_item_t;

  typedef struct packed {
    logic outside;
    logic overlap;
  } fct_flags_t;

endpackage

// ===== src/fct_plane.sv =====
// One plane evaluator: products stage, then distance sum and compare stage.
// Depends on fct_pkg.
module fct_plane import fct_pkg::*; (
  input  logic              clk_i,
  input  fct_item_t         item_i,
  input  logic [3*NormalW-1:0] normal_i,
  input  logic [CoordW-1:0] offset_i,
  output fct_flags_t        flags_o
);

  logic signed [NormalW-1:0] nrm [3];
  logic signed [CoordW-1:0]  pt  [3];
  logic signed [CoordW-1:0]  fr  [3];
  logic signed [CoordW-1:0]  va  [3];
  logic signed [CoordW-1:0]  vb  [3];
  logic signed [ProdW-1:0]   pa_d [3];
  logic signed [ProdW-1:0]   pb_d [3];
  logic signed [ProdW-1:0]   pa_q [3];
  logic signed [ProdW-1:0]   pb_q [3];
  logic signed [CoordW-1:0]  d_q;
  logic signed [CoordW-1:0]  r_q;
  logic [1:0]                mode_q;
  logic signed [DistW-1:0]   fa;
  logic signed [DistW-1:0]   fb;
  logic signed [DistW-1:0]   rs;
  logic signed [DistW-1:0]   ds;
  fct_flags_t                flags_d;
  fct_flags_t                flags_q;

  always_comb begin
    pt[0] = $signed(item_i.px);
    pt[1] = $signed(item_i.py);
    pt[2] = $signed(item_i.pz);
    fr[0] = $signed(item_i.fx);
    fr[1] = $signed(item_i.fy);
    fr[2] = $signed(item_i.fz);
    for (int a = 0; a < 3; a++) begin
      nrm[a] = $signed(normal_i[a*NormalW +: NormalW]);
      // far vertex for boxes; the point itself otherwise
      va[a] = (item_i.mode == MODE_BOX && nrm[a] > 0) ? fr[a] : pt[a];
      vb[a] = (nrm[a] > 0) ? pt[a] : fr[a];
      pa_d[a] = ProdW'(nrm[a]) * ProdW'(va[a]);
      pb_d[a] = ProdW'(nrm[a]) * ProdW'(vb[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      pa_q[a] <= pa_d[a];
      pb_q[a] <= pb_d[a];
    end
    d_q    <= $signed(offset_i);
    r_q    <= $signed(item_i.rad);
    mode_q <= item_i.mode;
  end

  always_comb begin
    ds = DistW'(d_q) <<< FracSh;
    rs = DistW'(r_q) <<< FracSh;
    fa = DistW'(pa_q[0]) + DistW'(pa_q[1]) + DistW'(pa_q[2]) + ds;
    fb = DistW'(pb_q[0]) + DistW'(pb_q[1]) + DistW'(pb_q[2]) + ds;
    flags_d = '0;
    case (mode_q)
      MODE_POINT: begin
        flags_d.outside = (fa <= 0);
      end
      MODE_SPHERE: begin
        flags_d.outside = (fa < -rs);
        flags_d.overlap = !(fa < -rs) && (fa <= rs);
      end
      MODE_BOX: begin
        flags_d.outside = (fa <= 0);
        flags_d.overlap = (fb <= 0);
      end
      default: flags_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
  end

  assign flags_o = flags_q;

endmodule

// ===== src/frustum_cull_tester.sv =====
// Frustum cull tester; item, products, flags and verdict are each registered.
// Throughput one item per cycle; busy is never raised.
// Loads write the plane store at accept and produce no result.
// Reset (rst_ni low, async) clears all planes to zero and the pipeline valids.
// Depends on fct_pkg and fct_plane.
module frustum_cull_tester import fct_pkg::*; #(
  parameter int unsigned NUM_PLANES = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                mode_i,
  input  logic [2:0]                plane_index_i,
  input  logic signed [31:0]        point_x_i,
  input  logic signed [31:0]        point_y_i,
  input  logic signed [31:0]        point_z_i,
  input  logic signed [31:0]        far_x_i,
  input  logic signed [31:0]        far_y_i,
  input  logic signed [31:0]        far_z_i,
  input  logic signed [31:0]        radius_or_offset_i,
  input  logic signed [15:0]        normal_x_i,
  input  logic signed [15:0]        normal_y_i,
  input  logic signed [15:0]        normal_z_i,
  output logic                      verdict_valid_o,
  output logic [1:0]                verdict_o
);

  logic                     accept;
  logic                     load;
  logic [3*NormalW-1:0]     normal_q [NUM_PLANES];
  logic [CoordW-1:0]        offset_q [NUM_PLANES];
  fct_item_t                item_q;
  logic                     v1_q, v2_q, v3_q;
  fct_flags_t               flags [NUM_PLANES];
  logic                     any_out;
  logic                     any_ovl;
  logic                     valid_q;
  logic [1:0]               verdict_d;
  logic [1:0]               verdict_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign load   = accept && (mode_i == MODE_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        normal_q[p] <= '0;
        offset_q[p] <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        if (load && 32'(plane_index_i) == p) begin
          normal_q[p] <= {normal_z_i, normal_y_i, normal_x_i};
          offset_q[p] <= radius_or_offset_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q.mode <= mode_i;
    item_q.px   <= point_x_i;
    item_q.py   <= point_y_i;
    item_q.pz   <= point_z_i;
    item_q.fx   <= far_x_i;
    item_q.fy   <= far_y_i;
    item_q.fz   <= far_z_i;
    item_q.rad  <= radius_or_offset_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      v1_q    <= accept && (mode_i != MODE_LOAD);
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      valid_q <= v3_q;
    end
  end

  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
    fct_plane u_plane (
      .clk_i    (clk_i),
      .item_i   (item_q),
      .normal_i (normal_q[g]),
      .offset_i (offset_q[g]),
      .flags_o  (flags[g])
    );
  end

  always_comb begin
    any_out = 1'b0;
    any_ovl = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      any_out = any_out | flags[p].outside;
      any_ovl = any_ovl | flags[p].overlap;
    end
    if (any_out) begin
      verdict_d = VERDICT_OUTSIDE;
    end else if (any_ovl) begin
      verdict_d = VERDICT_OVERLAP;
    end else begin
      verdict_d = VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign verdict_valid_o = valid_q;
  assign verdict_o       = verdict_q;

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_valid_o |-> (verdict_o == VERDICT_OUTSIDE || verdict_o == VERDICT_INSIDE ||
                         verdict_o == VERDICT_OVERLAP))
    else $error("verdict code out of range");

  a_test_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i != MODE_LOAD) |-> ##4 verdict_valid_o)
    else $error("test item lost its verdict");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == MODE_LOAD) |-> ##4 !verdict_valid_o)
    else $error("load item produced a verdict");

endmodule
